### rtl/sbm_pkg.sv
// Shared types, constants and the bin-to-band map of the spectrum band meter.
package sbm_pkg;

	localparam int unsigned NUM_BANDS      = 8;
	localparam int unsigned BAND_W         = 3;
	localparam int unsigned BIN_INDEX_BITS = 9;
	localparam int unsigned GAIN_W         = 16;
	localparam int unsigned LEVEL_W        = 8;
	localparam int unsigned TIME_W         = 32;

	localparam int unsigned NOISE_FLOOR = 500;
	localparam int unsigned IDLE_MS     = 135;
	localparam int unsigned LEVEL_MAX   = 200;
	localparam int unsigned LEVEL_DECAY = 4;
	localparam int unsigned PEAK_DECAY  = 2;

	// Upper bin of bands five and six
	localparam int unsigned BAND5_TOP = 106;
	localparam int unsigned BAND6_TOP = 400;

	localparam logic [GAIN_W-1:0] GAIN_RESET [NUM_BANDS] = '{
		16'd50, 16'd40, 16'd40, 16'd40, 16'd25, 16'd25, 16'd65, 16'd55
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_BIN_OUT,
		ST_FRAME
	} state_t;

	typedef struct packed {
		logic              hit;
		logic [BAND_W-1:0] idx;
	} band_sel_t;

	// Map an FFT bin to its band; bins below two and bins five and six hit nothing
	function automatic band_sel_t band_of(input logic [BIN_INDEX_BITS-1:0] bin);
		band_sel_t sel;
		sel.hit = 1'b1;
		priority if (bin < 9'd2) begin
			sel.hit = 1'b0;
			sel.idx = '0;
		end else if (bin <= 9'd4) begin
			sel.idx = 3'd0;
		end else if (bin <= 9'd6) begin
			sel.hit = 1'b0;
			sel.idx = '0;
		end else if (bin <= 9'd10) begin
			sel.idx = 3'd1;
		end else if (bin <= 9'd14) begin
			sel.idx = 3'd2;
		end else if (bin <= 9'd30) begin
			sel.idx = 3'd3;
		end else if (bin <= 9'd60) begin
			sel.idx = 3'd4;
		end else if (bin <= BIN_INDEX_BITS'(BAND5_TOP)) begin
			sel.idx = 3'd5;
		end else if (bin <= BIN_INDEX_BITS'(BAND6_TOP)) begin
			sel.idx = 3'd6;
		end else begin
			sel.idx = 3'd7;
		end
		return sel;
	endfunction

endpackage

### rtl/spectrum_band_meter.sv
// Eight-band spectrum bar meter with peak hold, shared bit-serial divider.
//
// Input channel (in_valid / in_stall): cmd 0 carries a bin_index and magnitude,
// cmd 1 marks the end of a frame; both carry now_ms. Output channel (out_valid /
// out_stall) returns band, level, peak, peak_changed, is_frame, last. The user
// writes gains (cfg_we/cfg_addr/cfg_wdata) only while the block is idle, unchecked.
//
// A bin at or below the noise floor or outside every band is dropped in its accept
// cycle. A kept bin runs the restoring divider, one quotient bit a cycle, and
// then reports once the output register is free; the next item is accepted
// after that. A frame end sweeps the eight bands, one band a cycle while the
// output is not stalled, and reports all eight. in_stall is high for the whole
// of an item's work. The result sits in an output register, so the block takes
// the next item while it waits there; a stalled receiver holds the sweep or the
// division report until it takes the pending transaction. Reset restores the
// default gains and clears every level, peak, shown peak and update time; the
// block is ready right after reset.
module spectrum_band_meter
	import sbm_pkg::*;
#(
	parameter int unsigned MAG_BITS = 24
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration
	input  logic                      cfg_we,
	input  logic [BAND_W-1:0]         cfg_addr,
	input  logic [GAIN_W-1:0]         cfg_wdata,
	// input channel
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      cmd,
	input  logic [BIN_INDEX_BITS-1:0] bin_index,
	input  logic [MAG_BITS-1:0]       magnitude,
	input  logic [TIME_W-1:0]         now_ms,
	// output channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [BAND_W-1:0]         band,
	output logic [LEVEL_W-1:0]        level,
	output logic [LEVEL_W-1:0]        peak,
	output logic                      peak_changed,
	output logic                      is_frame,
	output logic                      last
);

	localparam int unsigned CNT_W = $clog2(MAG_BITS + 1);

	state_t state_q, state_d;

	logic [GAIN_W-1:0]  gain_q       [NUM_BANDS];
	logic [LEVEL_W-1:0] level_q      [NUM_BANDS];
	logic [LEVEL_W-1:0] peak_q       [NUM_BANDS];
	logic [LEVEL_W-1:0] shown_q      [NUM_BANDS];
	logic [TIME_W-1:0]  upd_time_q   [NUM_BANDS];

	logic [BAND_W-1:0]   band_q;
	logic [TIME_W-1:0]   now_q;
	logic [GAIN_W-1:0]   div_gain_q;
	logic [GAIN_W-1:0]   rem_q;
	logic [MAG_BITS-1:0] dvd_q;
	logic [CNT_W-1:0]    cnt_q;

	logic                out_valid_q;
	logic [BAND_W-1:0]   out_band_q;
	logic [LEVEL_W-1:0]  out_level_q;
	logic [LEVEL_W-1:0]  out_peak_q;
	logic                out_chg_q;
	logic                out_frame_q;
	logic                out_last_q;

	logic      in_acc;
	logic      out_free;
	band_sel_t sel;
	logic      bin_keep;
	logic      start_div;
	logic      start_frame;
	logic      div_step;
	logic      bin_load;
	logic      frame_load;

	// divider datapath
	logic [GAIN_W:0]    trial;
	logic [GAIN_W:0]    trial_diff;
	logic               trial_ge;
	logic [LEVEL_W-1:0] bin_level;
	logic [LEVEL_W-1:0] bin_peak;

	// frame sweep datapath
	logic [TIME_W-1:0]  age;
	logic               band_idle;
	logic [LEVEL_W-1:0] lvl_cur;
	logic [LEVEL_W-1:0] lvl_dec;
	logic [LEVEL_W-1:0] lvl_new;
	logic [LEVEL_W-1:0] pk_raised;
	logic [LEVEL_W-1:0] pk_new;
	logic               pk_chg;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Classify the incoming item
	assign sel      = band_of(bin_index);
	assign bin_keep = sel.hit && (magnitude > MAG_BITS'(NOISE_FLOOR));

	// One restoring division step
	assign trial      = {rem_q, dvd_q[MAG_BITS-1]};
	assign trial_ge   = trial >= {1'b0, div_gain_q};
	assign trial_diff = trial - {1'b0, div_gain_q};

	// Clamp the quotient and raise the peak
	assign bin_level = (dvd_q > MAG_BITS'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX)
		: dvd_q[LEVEL_W-1:0];
	assign bin_peak  = (bin_level > peak_q[band_q]) ? bin_level : peak_q[band_q];

	// Decay one band at the frame end
	assign age       = now_q - upd_time_q[band_q];
	assign band_idle = age > TIME_W'(IDLE_MS);
	assign lvl_cur   = level_q[band_q];
	assign lvl_dec   = (lvl_cur > LEVEL_W'(LEVEL_DECAY)) ? lvl_cur - LEVEL_W'(LEVEL_DECAY) : '0;
	assign lvl_new   = band_idle ? lvl_dec : lvl_cur;
	assign pk_raised = (band_idle && (lvl_new > peak_q[band_q])) ? lvl_new : peak_q[band_q];
	assign pk_new    = (pk_raised > LEVEL_W'(PEAK_DECAY)) ? pk_raised - LEVEL_W'(PEAK_DECAY) : '0;
	assign pk_chg    = (shown_q[band_q] != pk_new);

	// Hold the sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Advance the sequencer
	always_comb begin
		state_d     = state_q;
		start_div   = 1'b0;
		start_frame = 1'b0;
		div_step    = 1'b0;
		bin_load    = 1'b0;
		frame_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && cmd) begin
					start_frame = 1'b1;
					state_d     = ST_FRAME;
				end else if (in_acc && bin_keep) begin
					start_div = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				div_step = 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					state_d = ST_BIN_OUT;
				end
			end
			ST_BIN_OUT: begin
				if (out_free) begin
					bin_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_FRAME: begin
				if (out_free) begin
					frame_load = 1'b1;
					if (band_q == BAND_W'(NUM_BANDS - 1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Latch the item, run the divider and step the frame sweep
	always_ff @(posedge clk) begin
		if (start_div) begin
			band_q     <= sel.idx;
			now_q      <= now_ms;
			div_gain_q <= gain_q[sel.idx];
			rem_q      <= '0;
			dvd_q      <= magnitude;
			cnt_q      <= CNT_W'(MAG_BITS);
		end else if (start_frame) begin
			band_q <= '0;
			now_q  <= now_ms;
		end else if (div_step) begin
			rem_q <= trial_ge ? trial_diff[GAIN_W-1:0] : trial[GAIN_W-1:0];
			dvd_q <= {dvd_q[MAG_BITS-2:0], trial_ge};
			cnt_q <= cnt_q - CNT_W'(1);
		end else if (frame_load) begin
			band_q <= band_q + BAND_W'(1);
		end
	end

	// Write gains and band state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BANDS; i++) begin
				gain_q[i]     <= GAIN_RESET[i];
				level_q[i]    <= '0;
				peak_q[i]     <= '0;
				shown_q[i]    <= '0;
				upd_time_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				gain_q[cfg_addr] <= cfg_wdata;
			end
			if (bin_load) begin
				level_q[band_q]    <= bin_level;
				peak_q[band_q]     <= bin_peak;
				upd_time_q[band_q] <= now_q;
			end else if (frame_load) begin
				level_q[band_q] <= lvl_new;
				peak_q[band_q]  <= pk_new;
				shown_q[band_q] <= pk_new;
				if (band_idle) begin
					upd_time_q[band_q] <= now_q;
				end
			end
		end
	end

	// Hold the output transaction until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (bin_load || frame_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (bin_load) begin
			out_band_q  <= band_q;
			out_level_q <= bin_level;
			out_peak_q  <= bin_peak;
			out_chg_q   <= 1'b0;
			out_frame_q <= 1'b0;
			out_last_q  <= 1'b1;
		end else if (frame_load) begin
			out_band_q  <= band_q;
			out_level_q <= lvl_new;
			out_peak_q  <= pk_new;
			out_chg_q   <= pk_chg;
			out_frame_q <= 1'b1;
			out_last_q  <= (band_q == BAND_W'(NUM_BANDS - 1));
		end
	end

	assign out_valid    = out_valid_q;
	assign band         = out_band_q;
	assign level        = out_level_q;
	assign peak         = out_peak_q;
	assign peak_changed = out_chg_q;
	assign is_frame     = out_frame_q;
	assign last         = out_last_q;

	// Reported values stay in the bar range
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (level <= LEVEL_W'(LEVEL_MAX)) && (peak <= LEVEL_W'(LEVEL_MAX)))
		else $error("reported level or peak above full scale");

	// A bin report holds its peak at or above its level, sets last and clears peak_changed
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_frame |-> (peak >= level) && last && !peak_changed)
		else $error("bin report with bad peak or flags");

	// Only the last band of a sweep closes the frame
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_frame |-> (last == (band == BAND_W'(NUM_BANDS - 1))))
		else $error("frame report with wrong last flag");

	// The divider finishes into the report state
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) && (cnt_q == CNT_W'(1)) |=> (state_q == ST_BIN_OUT))
		else $error("division did not end in the report state");

	// A new report never overwrites a waiting one
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !bin_load && !frame_load)
		else $error("output register overwritten while stalled");

endmodule
